// ===== rtl/core/sdfs_pkg.sv =====
// Shared constants, register indexes and state type for the sprite direction and frame selector.
package sdfs_pkg;

  localparam int MAX_DIRECTIONS = 8;
  localparam int ANGLE_BITS     = 16;
  localparam int DIR_BITS       = $clog2(MAX_DIRECTIONS);
  localparam int REQ_BITS       = 32;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COUNT_BITS     = 8;
  localparam int DIVISOR_BITS   = COUNT_BITS + 1;
  localparam int BIT_CNT_BITS   = $clog2(REQ_BITS);

  localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION_COUNT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP_MODE       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLES_FIRST    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLES_LAST     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COUNTS    = 3'd4;

  localparam logic [1:0] WRAP_MODULO = 2'd0;
  localparam logic [1:0] WRAP_CLAMP  = 2'd1;
  localparam logic [1:0] WRAP_ZIGZAG = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] FRAME_COUNTS_RESET = 64'h0101_0101_0101_0101;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/core/sprite_direction_frame_select.sv =====
// Top level of the sprite direction and frame selector: direction scan, serial modulo, output register.
// Each transfer on the input channel loads either the heading or the frame request, then yields
// exactly one result. The block handles one item at a time: after the accepting cycle it scans
// the directions in use one per cycle, picks the frame count in a preparation state,
// and, only when the request lies outside the frame range under modulo wrapping or under zigzag
// wrapping with more than one frame, runs a restoring remainder that takes one bit of the 32-bit
// request per cycle, followed by a correction step. The result then waits in an output register
// so a new item can be taken meanwhile; the final state stalls until that register is free.
module sprite_direction_frame_select
  import sdfs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      func,
  input  logic [15:0]               heading,
  input  logic signed [31:0]        frame_request,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                direction_index,
  output logic [7:0]                frame_number
);

  // Configuration registers.
  logic [3:0]               direction_count;
  logic [1:0]               wrap_mode;
  logic [CFG_DATA_BITS-1:0] angles_first_four;
  logic [CFG_DATA_BITS-1:0] angles_last_four;
  logic [CFG_DATA_BITS-1:0] frame_counts;

  // Held item state.
  logic [15:0]         held_heading;
  logic [REQ_BITS-1:0] held_frame_request;

  state_t state, state_next;

  logic [DIR_BITS-1:0]     scan_idx;
  logic [DIR_BITS-1:0]     best;
  logic [ANGLE_BITS-1:0]   best_dist;
  logic [COUNT_BITS-1:0]   n_reg;
  logic [DIVISOR_BITS-1:0] divisor;
  logic [REQ_BITS-1:0]     shreg;
  logic [DIVISOR_BITS-1:0] rem;
  logic [BIT_CNT_BITS-1:0] bit_cnt;
  logic                    req_neg;
  logic [COUNT_BITS-1:0]   res;

  logic                    fin_load;
  logic                    scan_done;
  logic                    prep_divide;
  logic [DIR_BITS-1:0]     scan_last;
  logic [127:0]            angles_all;
  logic [ANGLE_BITS-1:0]   cur_angle;
  logic [ANGLE_BITS-1:0]   head;
  logic [ANGLE_BITS-1:0]   cur_dist;
  logic [COUNT_BITS-1:0]   n_raw;
  logic [COUNT_BITS-1:0]   n_eff;
  logic                    in_range;
  logic [REQ_BITS-1:0]     req_mag;
  logic [DIVISOR_BITS:0]   rem_sh;
  logic [DIVISOR_BITS-1:0] rem_step;
  logic [DIVISOR_BITS-1:0] fold1;
  logic [DIVISOR_BITS-1:0] fold2;

  // Effective direction count: zero acts as one, anything above the maximum saturates.
  always_comb begin
    if (direction_count == 4'd0) begin
      scan_last = '0;
    end else if (direction_count > 4'(MAX_DIRECTIONS)) begin
      scan_last = DIR_BITS'(MAX_DIRECTIONS - 1);
    end else begin
      scan_last = DIR_BITS'(direction_count - 4'd1);
    end
  end

  assign angles_all = {angles_last_four, angles_first_four};
  assign cur_angle  = angles_all[{scan_idx, 4'b0000} +: ANGLE_BITS];
  assign head       = held_heading[ANGLE_BITS-1:0];
  assign cur_dist   = (cur_angle >= head) ? (cur_angle - head) : (head - cur_angle);
  assign scan_done  = (scan_idx == scan_last);

  assign n_raw    = frame_counts[{best, 3'b000} +: COUNT_BITS];
  assign n_eff    = (n_raw == '0) ? COUNT_BITS'(1) : n_raw;
  assign req_neg  = held_frame_request[REQ_BITS-1];
  assign in_range = !req_neg && (held_frame_request[REQ_BITS-2:COUNT_BITS] == '0)
                    && (held_frame_request[COUNT_BITS-1:0] < n_eff);
  assign req_mag  = req_neg ? (~held_frame_request + REQ_BITS'(1)) : held_frame_request;

  // Modulo and zigzag go through the remainder unless the request is in range or zigzag has
  // a single frame.
  assign prep_divide = !in_range
                       && ((wrap_mode == WRAP_MODULO)
                           || ((wrap_mode == WRAP_ZIGZAG) && (n_eff != COUNT_BITS'(1))));

  // One restoring step per cycle.
  assign rem_sh   = {rem, shreg[REQ_BITS-1]};
  assign rem_step = (rem_sh >= {1'b0, divisor}) ? DIVISOR_BITS'(rem_sh - {1'b0, divisor})
                                                : rem_sh[DIVISOR_BITS-1:0];

  // Truncated remainder of the magnitude becomes a floored one, then zigzag mirrors it.
  assign fold1 = (req_neg && (rem != '0)) ? (divisor - rem) : rem;
  assign fold2 = ((wrap_mode == WRAP_ZIGZAG) && (fold1 >= {1'b0, n_reg})) ? (divisor - fold1)
                                                                         : fold1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = prep_divide ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (bit_cnt == '0) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (fin_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    fin_load = (state == ST_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_count    <= 4'd1;
      wrap_mode          <= WRAP_MODULO;
      angles_first_four  <= '0;
      angles_last_four   <= '0;
      frame_counts       <= FRAME_COUNTS_RESET;
      held_heading       <= '0;
      held_frame_request <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIRECTION_COUNT: direction_count   <= cfg_data[3:0];
          REG_WRAP_MODE:       wrap_mode         <= cfg_data[1:0];
          REG_ANGLES_FIRST:    angles_first_four <= cfg_data;
          REG_ANGLES_LAST:     angles_last_four  <= cfg_data;
          REG_FRAME_COUNTS:    frame_counts      <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        if (func) begin
          held_frame_request <= frame_request;
        end else begin
          held_heading <= heading;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        scan_idx <= '0;
      end
      ST_SCAN: begin
        // The first direction always takes the lead; later ones need a strictly smaller distance.
        if ((scan_idx == '0) || (cur_dist < best_dist)) begin
          best      <= scan_idx;
          best_dist <= cur_dist;
        end
        scan_idx <= scan_idx + DIR_BITS'(1);
      end
      ST_PREP: begin
        n_reg   <= n_eff;
        shreg   <= req_mag;
        rem     <= '0;
        bit_cnt <= BIT_CNT_BITS'(REQ_BITS - 1);
        if (wrap_mode == WRAP_ZIGZAG) begin
          divisor <= {n_eff, 1'b0} - DIVISOR_BITS'(2);
        end else begin
          divisor <= {1'b0, n_eff};
        end
        if (in_range) begin
          res <= held_frame_request[COUNT_BITS-1:0];
        end else if (req_neg) begin
          res <= '0;
        end else if (wrap_mode == WRAP_ZIGZAG) begin
          res <= '0;
        end else begin
          res <= n_eff - COUNT_BITS'(1);
        end
      end
      ST_DIV: begin
        rem     <= rem_step;
        shreg   <= {shreg[REQ_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt - BIT_CNT_BITS'(1);
      end
      ST_FIX: begin
        res <= fold2[COUNT_BITS-1:0];
      end
      ST_FIN: begin
        if (fin_load) begin
          direction_index <= best;
          frame_number    <= res;
        end
      end
      default: begin
      end
    endcase
  end

  a_frame_not_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_number != 8'hFF))
    else $error("frame number reached 255");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < divisor))
    else $error("partial remainder not below divisor");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SCAN))
    else $error("accepted item did not start the direction scan");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP) |-> (best <= scan_last))
    else $error("chosen direction beyond the directions in use");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the sprite direction and frame selector.
`timescale 1ns / 1ps

module testbench
  import sdfs_pkg::*;
;

  localparam logic [1:0] WRAP_SPARE = 2'd3;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASES = 14;
  localparam int ITEMS_PER_PHASE = 102;

  typedef struct packed {
    logic [2:0] direction;
    logic [7:0] frame;
  } sprite_pick_t;

  // Mirrors the registers and held state, predicts each pick and checks the results in order.
  class sprite_pick_tracker;
    logic [3:0]  dir_count;
    logic [1:0]  wrap_mode;
    logic [63:0] angles_first;
    logic [63:0] angles_last;
    logic [63:0] frame_counts;
    logic [15:0] held_heading;
    logic signed [31:0] held_request;
    sprite_pick_t expected_picks[$];
    int fail_count;

    function new();
      dir_count = 4'd1;
      wrap_mode = WRAP_MODULO;
      angles_first = '0;
      angles_last = '0;
      frame_counts = FRAME_COUNTS_RESET;
      held_heading = '0;
      held_request = '0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] data);
      case (idx)
        REG_DIRECTION_COUNT: dir_count = data[3:0];
        REG_WRAP_MODE:       wrap_mode = data[1:0];
        REG_ANGLES_FIRST:    angles_first = data;
        REG_ANGLES_LAST:     angles_last = data;
        REG_FRAME_COUNTS:    frame_counts = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] angle_of(int d);
      logic [63:0] word;
      word = (d < 4) ? angles_first : angles_last;
      return word[(d % 4) * 16 +: 16] & 16'((32'd1 << ANGLE_BITS) - 1);
    endfunction

    static function longint floored_rem(longint a, longint n);
      longint m;
      m = a % n;
      if (m < 0) m += n;
      return m;
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    function void note_transfer(logic f, logic [15:0] h, logic signed [31:0] r);
      int unsigned count, best, best_dist, span, a, head;
      longint req, n, p, m;
      sprite_pick_t pick;
      if (!f) held_heading = h;
      else held_request = r;
      count = (dir_count == 0) ? 1 :
              ((dir_count > MAX_DIRECTIONS) ? MAX_DIRECTIONS : dir_count);
      head = held_heading & ((32'd1 << ANGLE_BITS) - 1);
      best = 0;
      best_dist = 32'hFFFF_FFFF;
      for (int d = 0; d < count; d++) begin
        a = angle_of(d);
        span = (a >= head) ? a - head : head - a;
        // Strict compare keeps the lowest index on a tie.
        if (span < best_dist) begin
          best_dist = span;
          best = d;
        end
      end
      n = frame_counts[best * 8 +: 8];
      if (n == 0) n = 1;
      req = held_request;
      if (req >= 0 && req < n) begin
        m = req;
      end else if (wrap_mode == WRAP_MODULO) begin
        m = floored_rem(req, n);
      end else if (wrap_mode == WRAP_ZIGZAG) begin
        if (n == 1) begin
          m = 0;
        end else begin
          p = 2 * n - 2;
          m = floored_rem(req, p);
          if (m >= n) m = p - m;
        end
      end else begin
        m = (req < 0) ? 0 : ((req > n - 1) ? n - 1 : req);
      end
      pick.direction = best[2:0];
      pick.frame = m[7:0];
      expected_picks = {expected_picks, pick};
    endfunction

    function void check_result(logic [2:0] dir, logic [7:0] frame);
      sprite_pick_t want;
      if (expected_picks.size() == 0) begin
        $error("unexpected result: direction_index %0d frame_number %0d", dir, frame);
        fail_count++;
        return;
      end
      want = expected_picks.pop_front();
      if (dir !== want.direction) begin
        $error("direction_index: expected %0d, got %0d", want.direction, dir);
        fail_count++;
      end
      if (frame !== want.frame) begin
        $error("frame_number: expected %0d, got %0d", want.frame, frame);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [15:0] heading = '0;
  logic signed [31:0] frame_request = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] direction_index;
  logic [7:0] frame_number;

  sprite_pick_tracker picks = new();
  bit hold_off_request = 1'b0;

  sprite_direction_frame_select dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .heading(heading),
    .frame_request(frame_request),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .direction_index(direction_index),
    .frame_number(frame_number)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) picks.check_result(direction_index, frame_number);
  end

  // Receiver: stretches of steady, random or sparse readiness, plus one long hold-off on request.
  initial begin
    int stretch, style;
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        stretch = $urandom_range(20, 200);
        style = $urandom_range(0, 2);
        repeat (stretch) begin
          @(negedge clk);
          case (style)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    picks.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one item and returns at the edge where the transfer happens.
  task automatic send_item(logic f, logic [15:0] h, logic signed [31:0] r);
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    heading <= h;
    frame_request <= r;
    do @(posedge clk); while (!in_ready);
    picks.note_transfer(f, h, r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (picks.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] random_angle_word(int style, logic [15:0] base, int half);
    logic [63:0] word;
    logic [15:0] a;
    for (int k = 0; k < 4; k++) begin
      case (style)
        0: a = base + 16'((half * 4 + k) * 8192);
        1: a = 16'($urandom);
        2: a = ($urandom_range(0, 1) != 0) ? base : base + 16'd2;
        default: a = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      endcase
      word[k * 16 +: 16] = a;
    end
    return word;
  endfunction

  task automatic apply_random_setting(int phase);
    logic [3:0] count;
    logic [63:0] counts;
    logic [15:0] base;
    int style;
    case (phase)
      0: count = 4'd8;
      1: count = 4'd1;
      2: count = 4'd0;
      3: count = 4'd15;
      default: count = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 8))
                                                    : 4'($urandom_range(0, 15));
    endcase
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 4))
        0: counts[k * 8 +: 8] = 8'd0;
        1: counts[k * 8 +: 8] = 8'd1;
        2: counts[k * 8 +: 8] = 8'd2;
        3: counts[k * 8 +: 8] = 8'd255;
        default: counts[k * 8 +: 8] = 8'($urandom);
      endcase
    end
    if (phase == 1) counts = '1;
    if (phase == 2) counts = '0;
    style = $urandom_range(0, 3);
    base = 16'($urandom);
    write_reg(REG_DIRECTION_COUNT, {60'($urandom), count});
    write_reg(REG_WRAP_MODE, {62'($urandom), 2'(phase % 4)});
    write_reg(REG_ANGLES_FIRST, random_angle_word(style, base, 0));
    write_reg(REG_ANGLES_LAST, random_angle_word(style, base, 1));
    write_reg(REG_FRAME_COUNTS, counts);
  endtask

  task automatic send_random_item();
    logic f;
    logic [15:0] h;
    logic signed [31:0] r;
    f = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: h = 16'($urandom);
      5, 6, 7: h = picks.angle_of($urandom_range(0, 7)) + 16'($urandom_range(0, 6)) - 16'd3;
      default: begin
        case ($urandom_range(0, 3))
          0: h = 16'h0000;
          1: h = 16'hFFFF;
          2: h = 16'h8000;
          default: h = 16'h7FFF;
        endcase
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: r = $urandom_range(0, 300);
      3, 4, 5: r = 32'($urandom_range(0, 1200)) - 32'sd600;
      6, 7, 8: r = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: r = 32'sh8000_0000;
          1: r = 32'sh7FFF_FFFF;
          2: r = -32'sd1;
          default: r = 32'sd0;
        endcase
      end
    endcase
    send_item(f, h, r);
  endtask

  initial begin
    int burst_left, gap;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: one direction, one frame, modulo.
    send_item(1'b0, 16'hFFFF, 32'sd0);
    send_item(1'b1, 16'h1234, -32'sd1);
    send_item(1'b1, 16'h0000, 32'sh7FFF_FFFF);
    wait_drained();

    // Four directions a quarter turn apart; frame counts 1, 5, 255 and a zero count.
    write_reg(REG_DIRECTION_COUNT, 64'd4);
    write_reg(REG_WRAP_MODE, {62'd0, WRAP_MODULO});
    write_reg(REG_ANGLES_FIRST, 64'hC000_8000_4000_0000);
    write_reg(REG_ANGLES_LAST, {$urandom, $urandom});
    write_reg(REG_FRAME_COUNTS, 64'h0707_0707_00FF_0501);
    send_item(1'b0, 16'h4100, 32'sd0);
    send_item(1'b1, 16'h0000, -32'sd1);
    send_item(1'b1, 16'h0000, 32'sd5);
    send_item(1'b1, 16'h0000, 32'sh8000_0000);
    send_item(1'b0, 16'h8000, 32'sd0);
    send_item(1'b1, 16'h0000, 32'sh7FFF_FFFF);
    send_item(1'b1, 16'h0000, 32'sd254);
    send_item(1'b0, 16'hFFFF, 32'sd0);
    wait_drained();

    // Zigzag, including a direction with a single frame.
    write_reg(REG_WRAP_MODE, {62'd0, WRAP_ZIGZAG});
    send_item(1'b0, 16'h4000, 32'sd0);
    send_item(1'b1, 16'h0000, 32'sd5);
    send_item(1'b1, 16'h0000, 32'sd8);
    send_item(1'b1, 16'h0000, -32'sd3);
    send_item(1'b0, 16'h0000, 32'sd0);
    wait_drained();

    // The spare wrap mode clamps; a zero direction count acts as one.
    write_reg(REG_WRAP_MODE, {62'd0, WRAP_SPARE});
    write_reg(REG_DIRECTION_COUNT, 64'd0);
    write_reg(REG_FRAME_COUNTS, 64'h0707_0707_00FF_050A);
    send_item(1'b1, 16'h0000, -32'sd7);
    send_item(1'b1, 16'h0000, 32'sd1000);
    wait_drained();

    // Saturated direction count, all angles tied, and writes past the register list.
    write_reg(REG_WRAP_MODE, {62'd0, WRAP_CLAMP});
    write_reg(REG_DIRECTION_COUNT, 64'd15);
    write_reg(REG_ANGLES_FIRST, 64'h1234_1234_1234_1234);
    write_reg(REG_ANGLES_LAST, 64'h1234_1234_1234_1234);
    for (int i = int'(REG_FRAME_COUNTS) + 1; i < (1 << CFG_INDEX_BITS); i++) begin
      write_reg(i[CFG_INDEX_BITS-1:0], {$urandom, $urandom});
    end
    send_item(1'b0, 16'h0000, 32'sd0);
    send_item(1'b0, 16'hFFFF, 32'sd0);
    send_item(1'b1, 16'h0000, 32'sh8000_0000);
    wait_drained();

    burst_left = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_random_setting(phase);
      // In this phase the receiver holds off while items keep coming with no gaps.
      if (phase == 3) hold_off_request = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 5 && i == ITEMS_PER_PHASE / 2) begin
          wait_drained();
          burst_left = 0;
        end
        if (burst_left == 0 && phase != 3) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        send_random_item();
        if (burst_left > 0) burst_left--;
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (picks.fail_count == 0 && picks.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
